@@ sv/rpd_pkg.sv @@
// shared constants, command and status types and the piecewise log function
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int PEAKS_PER_FRAME    = 8;
  localparam int FRAMES_PER_SECTION = 10;
  localparam int WINDOW_SECTIONS    = 4;
  localparam int RANGE_BINS         = 32;

  localparam int BIN_W  = (RANGE_BINS > 1) ? $clog2(RANGE_BINS) : 1;
  localparam int SLOT_W = (WINDOW_SECTIONS > 1) ? $clog2(WINDOW_SECTIONS) : 1;
  localparam int POS_W  = 4;
  localparam int FC_W   = 8;
  localparam int DIV_STEPS = 8;
  localparam int STEP_W = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROI_MAX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_THD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_THD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_VEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_RES   = 3'd6;

  typedef struct packed {
    logic             capture;
    logic             setup;
    logic             check;
    logic             div_step;
    logic             mul;
    logic             range;
    logic             acc;
    logic             pass_rd;
    logic             pass_wr;
    logic             decay;
    logic             fin;
    logic [BIN_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic do_pass;
    logic pass_last;
    logic out_busy;
  } sts_t;

  // piecewise log of the low 16 bits, three fraction bits
  function automatic logic [6:0] log_piecewise(input logic [15:0] n);
    logic [3:0] b;
    logic [6:0] res;
    b = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (n[k]) begin
        b = 4'(k);
      end
    end
    if (b >= 4'd3) begin
      res = {b, 3'b000} + {4'b0000, 3'(n >> (b - 4'd3))};
    end else if (b == 4'd2) begin
      res = 7'd16 + {4'b0000, n[1:0], 1'b0};
    end else if (b == 4'd1) begin
      res = 7'd8 + {4'b0000, n[0], 2'b00};
    end else begin
      res = 7'd0;
    end
    return res;
  endfunction

endpackage

@@ sv/rpd_ctrl.sv @@
// frame sequencer: capture, division, accumulation and window pass
`timescale 1ns / 1ps

module rpd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_peak,
  output logic          in_ready,
  input  rpd_pkg::sts_t sts,
  output rpd_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_RANGE = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_BR    = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PWR   = 4'd9;
  localparam logic [3:0] S_DECAY = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]                   state_r, state_nxt;
  logic [rpd_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [rpd_pkg::BIN_W-1:0]    idx_r, idx_nxt;
  logic                         accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept && in_last_peak) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == rpd_pkg::STEP_W'(rpd_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        cmd.range = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_BR;
      end
      S_BR: begin
        idx_nxt   = '0;
        state_nxt = sts.do_pass ? S_PRD : S_FIN;
      end
      S_PRD: begin
        cmd.pass_rd = 1'b1;
        state_nxt   = S_PWR;
      end
      S_PWR: begin
        cmd.pass_wr = 1'b1;
        if (sts.pass_last) begin
          state_nxt = S_DECAY;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

@@ sv/rpd_dp.sv @@
// datapath: registers, peak capture, divider, stores and output register
`timescale 1ns / 1ps

module rpd_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]                     in_velocity_index,
  input  logic [7:0]                     in_range_index,
  input  logic [30:0]                    in_magnitude,
  input  rpd_pkg::cmd_t                  cmd,
  output rpd_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_presence,
  output logic                           out_motion_seen,
  output logic                           out_still_seen,
  output logic [15:0]                    out_range_estimate,
  output logic [15:0]                    out_level_max
);

  localparam int RB = rpd_pkg::RANGE_BINS;
  localparam int WS = rpd_pkg::WINDOW_SECTIONS;

  // configuration
  logic [4:0]  roi_max_r;
  logic [15:0] range_gate_r, still_thr_r, hold_len_r, move_thr_r;
  logic [7:0]  static_vel_r, range_res_r;

  // frame capture
  logic [rpd_pkg::POS_W-1:0] pos_r;
  logic [7:0]  main_vel_r, main_bin_r;
  logic [30:0] main_mag_r, left_mag_r, right_mag_r;
  logic [1:0]  nfound_r;

  // divider
  logic [31:0] absdiff_r;
  logic [35:0] absden_r, rem_r;
  logic        neg_r, den_zero_r, sat_r;
  logic [7:0]  quot_r;
  logic signed [26:0] prod_r;
  logic [15:0] range_r;

  // long-lived state
  logic [rpd_pkg::FC_W-1:0]   fc_r;
  logic [15:0]                sec_r [RB];
  logic [15:0]                wsum_r [RB];
  logic [15:0]                mem_r [WS][RB];
  logic [RB-1:0]              wvalid_r [WS];
  logic [rpd_pkg::SLOT_W-1:0] slot_r;
  logic [15:0]                dmax_r;
  logic                       present_r;
  logic [15:0]                hold_r;
  logic                       motion_r;
  logic [15:0]                rd_data_r;
  logic                       rd_valid_r;

  logic        out_valid_r, out_presence_r, out_motion_r, out_still_r;
  logic [15:0] out_range_r, out_level_r;

  // combinational helpers
  logic [30:0] l_eff, r_eff;
  logic signed [35:0] diff_s, den_s;
  logic [36:0] rem2;
  logic signed [9:0]  off_s;
  logic signed [17:0] val_s;
  logic signed [18:0] shr_s;
  logic [rpd_pkg::FC_W-1:0] fc_nxt;
  logic        sec_clear, accum, mot;
  logic [31:0] m_val;
  logic [rpd_pkg::BIN_W-1:0] sec_addr, limit;
  logic [15:0] sec_rd, old_w, wsum_new;
  logic        still;

  assign l_eff  = nfound_r[0] ? left_mag_r : 31'd0;
  assign r_eff  = nfound_r[1] ? right_mag_r : 31'd0;
  assign diff_s = $signed({5'd0, r_eff}) - $signed({5'd0, l_eff});
  assign den_s  = ($signed({5'd0, main_mag_r}) <<< 2)
                  - ($signed({5'd0, l_eff}) <<< 1) - ($signed({5'd0, r_eff}) <<< 1);
  assign rem2   = {rem_r, 1'b0};

  assign off_s = (main_mag_r == 31'd0 || den_zero_r) ? 10'sd0 :
                 sat_r ? (neg_r ? -10'sd255 : 10'sd255) :
                 (neg_r ? -$signed({2'b00, quot_r}) : $signed({2'b00, quot_r}));
  assign val_s = $signed({2'b00, main_bin_r, 8'd0}) + 18'(off_s);
  assign shr_s = 19'(prod_r >>> 8);

  assign fc_nxt = (fc_r == rpd_pkg::FC_W'(rpd_pkg::FRAMES_PER_SECTION - 1)) ? '0
                                                                             : fc_r + 1'b1;
  assign sec_clear = (fc_nxt == '0);
  assign mot   = (main_mag_r > {15'd0, move_thr_r}) && (main_bin_r <= {3'd0, roi_max_r});
  assign m_val = mot ? {16'd0, move_thr_r} : {1'b0, main_mag_r} + 32'd1;
  assign accum = (range_r < range_gate_r) && (main_vel_r == static_vel_r)
                 && (main_bin_r <= {3'd0, roi_max_r}) && ({1'b0, main_bin_r} < 9'(RB));

  // single section read port: pass index or main bin
  assign sec_addr = (cmd.pass_wr || cmd.pass_rd) ? cmd.idx : main_bin_r[rpd_pkg::BIN_W-1:0];
  assign sec_rd   = sec_r[sec_addr];
  assign limit    = ({4'd0, roi_max_r} < 9'(RB - 1)) ? rpd_pkg::BIN_W'(roi_max_r)
                                                     : rpd_pkg::BIN_W'(RB - 1);
  assign old_w    = rd_valid_r ? rd_data_r : 16'd0;
  assign wsum_new = wsum_r[cmd.idx] - old_w + sec_rd;
  assign still    = dmax_r > still_thr_r;

  assign sts.do_pass   = (fc_r == rpd_pkg::FC_W'(rpd_pkg::FRAMES_PER_SECTION - 1));
  assign sts.pass_last = (cmd.idx == limit);
  assign sts.out_busy  = out_valid_r && !out_ready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_max_r    <= 5'd31;
      range_gate_r <= 16'd65535;
      still_thr_r  <= 16'd100;
      hold_len_r   <= 16'd100;
      move_thr_r   <= 16'd1000;
      static_vel_r <= 8'd0;
      range_res_r  <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpd_pkg::CFG_ROI_MAX:     roi_max_r    <= cfg_wdata[4:0];
        rpd_pkg::CFG_VALID_RANGE: range_gate_r <= cfg_wdata;
        rpd_pkg::CFG_EXIT_THD:    still_thr_r  <= cfg_wdata;
        rpd_pkg::CFG_HOLD_TICKS:  hold_len_r   <= cfg_wdata;
        rpd_pkg::CFG_ENTER_THD:   move_thr_r   <= cfg_wdata;
        rpd_pkg::CFG_STATIC_VEL:  static_vel_r <= cfg_wdata[7:0];
        rpd_pkg::CFG_RANGE_RES:   range_res_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // peak capture and frame clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      main_vel_r  <= '0;
      main_bin_r  <= '0;
      main_mag_r  <= '0;
      left_mag_r  <= '0;
      right_mag_r <= '0;
      nfound_r    <= '0;
    end else if (cmd.fin) begin
      pos_r       <= '0;
      main_vel_r  <= '0;
      main_bin_r  <= '0;
      main_mag_r  <= '0;
      left_mag_r  <= '0;
      right_mag_r <= '0;
      nfound_r    <= '0;
    end else if (cmd.capture) begin
      if (pos_r == '0) begin
        main_vel_r <= in_velocity_index;
        main_bin_r <= in_range_index;
        main_mag_r <= in_magnitude;
        pos_r      <= rpd_pkg::POS_W'(1);
      end else if (pos_r < rpd_pkg::POS_W'(rpd_pkg::PEAKS_PER_FRAME)) begin
        if (!nfound_r[0] && ({1'b0, in_range_index} + 9'd1 == {1'b0, main_bin_r})) begin
          nfound_r[0] <= 1'b1;
          left_mag_r  <= in_magnitude;
        end
        if (!nfound_r[1] && ({1'b0, in_range_index} == {1'b0, main_bin_r} + 9'd1)) begin
          nfound_r[1] <= 1'b1;
          right_mag_r <= in_magnitude;
        end
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  // divider, multiply and clamp
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      absdiff_r  <= diff_s[35] ? 32'(-diff_s) : 32'(diff_s);
      absden_r   <= den_s[35] ? 36'(-den_s) : 36'(den_s);
      neg_r      <= diff_s[35] ^ den_s[35];
      den_zero_r <= (den_s == '0);
    end
    if (cmd.check) begin
      sat_r  <= ({4'd0, absdiff_r} >= absden_r);
      rem_r  <= {4'd0, absdiff_r};
      quot_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, absden_r}) begin
        rem_r  <= 36'(rem2 - {1'b0, absden_r});
        quot_r <= {quot_r[6:0], 1'b1};
      end else begin
        rem_r  <= rem2[35:0];
        quot_r <= {quot_r[6:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod_r <= 27'(val_s) * $signed({19'd0, range_res_r});
    end
    if (cmd.range) begin
      if (main_mag_r == 31'd0 || prod_r < 0) begin
        range_r <= 16'd0;
      end else if (shr_s > 19'sd65535) begin
        range_r <= 16'hFFFF;
      end else begin
        range_r <= shr_s[15:0];
      end
    end
  end

  // section sums, frame count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r     <= '0;
      motion_r <= 1'b0;
      for (int i = 0; i < RB; i++) begin
        sec_r[i] <= '0;
      end
    end else if (cmd.acc) begin
      fc_r     <= fc_nxt;
      motion_r <= mot && (range_r < range_gate_r);
      for (int i = 0; i < RB; i++) begin
        if (accum && (rpd_pkg::BIN_W'(i) == sec_addr)) begin
          sec_r[i] <= (sec_clear ? 16'd0 : sec_rd)
                      + {9'd0, rpd_pkg::log_piecewise(m_val[15:0])};
        end else if (sec_clear) begin
          sec_r[i] <= '0;
        end
      end
    end
  end

  // window store memory
  always_ff @(posedge clk) begin
    if (cmd.pass_rd) begin
      rd_data_r <= mem_r[slot_r][cmd.idx];
    end
    if (cmd.pass_wr) begin
      mem_r[slot_r][cmd.idx] <= sec_rd;
    end
  end

  // window sums, valid bits, slot, decaying maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      dmax_r     <= '0;
      rd_valid_r <= 1'b0;
      for (int s = 0; s < WS; s++) begin
        wvalid_r[s] <= '0;
      end
      for (int i = 0; i < RB; i++) begin
        wsum_r[i] <= '0;
      end
    end else begin
      if (cmd.pass_rd) begin
        rd_valid_r <= wvalid_r[slot_r][cmd.idx];
      end
      if (cmd.pass_wr) begin
        wsum_r[cmd.idx]           <= wsum_new;
        wvalid_r[slot_r][cmd.idx] <= 1'b1;
        if (wsum_new > dmax_r) begin
          dmax_r <= wsum_new;
        end
      end
      if (cmd.decay) begin
        dmax_r <= dmax_r >> 3;
        slot_r <= (slot_r == rpd_pkg::SLOT_W'(WS - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  // presence and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= 1'b0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        out_valid_r    <= 1'b1;
        out_motion_r   <= motion_r;
        out_still_r    <= still;
        out_range_r    <= range_r;
        out_level_r    <= dmax_r;
        if (motion_r || still) begin
          present_r      <= 1'b1;
          hold_r         <= '0;
          out_presence_r <= 1'b1;
        end else if (present_r) begin
          if (hold_r < hold_len_r) begin
            hold_r         <= hold_r + 1'b1;
            out_presence_r <= 1'b1;
          end else begin
            present_r      <= 1'b0;
            out_presence_r <= 1'b0;
          end
        end else begin
          out_presence_r <= 1'b0;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_presence       = out_presence_r;
  assign out_motion_seen    = out_motion_r;
  assign out_still_seen     = out_still_r;
  assign out_range_estimate = out_range_r;
  assign out_level_max      = out_level_r;

endmodule

@@ sv/radar_presence_detector_top.sv @@
// top level of the radar presence detector
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   velocity, range bin, magnitude, last peak
// out_      output     out_valid / out_ready presence, motion, still, range, level max
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// a peak that does not end a frame is captured on acceptance and the sequencer stays ready
// a frame-ending item runs setup, check, the divider steps, multiply, range and accumulate,
// plus, when a section closes, a window read and write per bin up to roi_max and a decay
// the centre-of-gravity offset comes from an 8-step restoring divider
// synchronous reset clears all stores at once through flip-flops and valid bits
// a result waiting at the output only stalls the next frame end, not plain peaks

module radar_presence_detector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_velocity_index,
  input  logic [7:0]                     in_range_index,
  input  logic [30:0]                    in_magnitude,
  input  logic                           in_last_peak,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_presence,
  output logic                           out_motion_seen,
  output logic                           out_still_seen,
  output logic [15:0]                    out_range_estimate,
  output logic [15:0]                    out_level_max,
  input  logic                           cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rpd_pkg::cmd_t cmd;
  rpd_pkg::sts_t sts;

  // sequencer
  rpd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_peak (in_last_peak),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // datapath with stores and result register
  rpd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_velocity_index  (in_velocity_index),
    .in_range_index     (in_range_index),
    .in_magnitude       (in_magnitude),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_presence       (out_presence),
    .out_motion_seen    (out_motion_seen),
    .out_still_seen     (out_still_seen),
    .out_range_estimate (out_range_estimate),
    .out_level_max      (out_level_max)
  );

endmodule

@@ sv/rpd_checker.sv @@
// port-level checks on the presence detector, bound to the top level
`timescale 1ns / 1ps

module rpd_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_presence,
  input logic        out_motion_seen,
  input logic        out_still_seen,
  input logic [15:0] out_range_estimate,
  input logic [15:0] out_level_max
);

  // a stalled item stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled item keeps its range estimate and level maximum
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_range_estimate) && $stable(out_level_max))
    else $error("result payload changed while stalled");

  // motion or a still person forces presence
  a_presence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motion_seen || out_still_seen) |-> out_presence)
    else $error("presence low despite detection");

  // nothing is shown straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind radar_presence_detector_top rpd_port_checks u_rpd_port_checks (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_presence       (out_presence),
  .out_motion_seen    (out_motion_seen),
  .out_still_seen     (out_still_seen),
  .out_range_estimate (out_range_estimate),
  .out_level_max      (out_level_max)
);
